FILE: src/swvm_pkg.sv
// ----------------------------------------------------------------------------
// swvm_pkg
// Shared types, constants and helper functions of the four-digit display
// driver.
// ----------------------------------------------------------------------------
package swvm_pkg;

  localparam int ADC_BITS_DEF     = 12;
  localparam int WRAP_SECONDS_DEF = 6000;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int CMD_W  = 2;
  localparam int ADC_W  = 12;
  localparam int FS_W   = 10;
  localparam int SEC_W  = 13;
  localparam int POS_W  = 2;
  localparam int SEG_W  = 8;
  localparam int SEL_W  = 4;
  localparam int PROD_W = ADC_W + FS_W;
  localparam int VAL_W  = 14;
  localparam int MIN_W  = 8;
  localparam int SECS_W = 6;
  localparam int DIG_W  = 4;
  localparam int MUL_W  = 32;

  localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [FS_W-1:0]  FS_RESET     = 10'd330;
  localparam logic [VAL_W-1:0] VAL_MAX      = 14'd9999;
  localparam logic [SEL_W-1:0] SEL_POS0     = 4'b1000;
  localparam logic [MUL_W-1:0] RECIP_60     = 32'd8739;
  localparam int               RECIP_60_SH  = 19;
  localparam logic [MUL_W-1:0] RECIP_10     = 32'd52429;
  localparam int               RECIP_10_SH  = 19;
  localparam logic [SEC_W-1:0] SECS_PER_MIN = 13'd60;
  localparam logic [VAL_W-1:0] TEN          = 14'd10;

  typedef struct packed {
    logic             show_volts;
    logic [ADC_W-1:0] adc_sample;
    logic [SEC_W-1:0] elapsed;
    logic [POS_W-1:0] pos;
  } swvm_job_t;

  function automatic logic [MUL_W-1:0] pow10_recip(input logic [POS_W-1:0] k);
    case (k)
      2'd0:    pow10_recip = 32'd1;
      2'd1:    pow10_recip = 32'd52429;
      2'd2:    pow10_recip = 32'd5243;
      2'd3:    pow10_recip = 32'd8389;
      default: pow10_recip = 32'd1;
    endcase
  endfunction

  function automatic logic [4:0] pow10_shift(input logic [POS_W-1:0] k);
    case (k)
      2'd0:    pow10_shift = 5'd0;
      2'd1:    pow10_shift = 5'd19;
      2'd2:    pow10_shift = 5'd19;
      2'd3:    pow10_shift = 5'd23;
      default: pow10_shift = 5'd0;
    endcase
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    case (d)
      4'd0:    seg_of = 8'hC0;
      4'd1:    seg_of = 8'hF9;
      4'd2:    seg_of = 8'hA4;
      4'd3:    seg_of = 8'hB0;
      4'd4:    seg_of = 8'h99;
      4'd5:    seg_of = 8'h92;
      4'd6:    seg_of = 8'h82;
      4'd7:    seg_of = 8'hF8;
      4'd8:    seg_of = 8'h80;
      4'd9:    seg_of = 8'h90;
      default: seg_of = 8'hFF;
    endcase
  endfunction

endpackage

FILE: src/swvm_ifs.sv
// ----------------------------------------------------------------------------
// swvm channel interfaces
// Valid/ready channels for commands, display frames and the scale register.
// ----------------------------------------------------------------------------
interface swvm_in_if;
  import swvm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic             show_volts;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, command, show_volts, adc_sample, input ready);
  modport sink (input valid, command, show_volts, adc_sample, output ready);
endinterface

interface swvm_out_if;
  import swvm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_code;
  logic [SEL_W-1:0] digit_select;
  logic [POS_W-1:0] digit_position;

  modport source (output valid, segment_code, digit_select, digit_position,
                  input ready);
  modport sink (input valid, segment_code, digit_select, digit_position,
                output ready);
endinterface

interface swvm_cfg_if;
  import swvm_pkg::*;
  logic            valid;
  logic            ready;
  logic [FS_W-1:0] full_scale_centivolts;

  modport source (output valid, full_scale_centivolts, input ready);
  modport sink (input valid, full_scale_centivolts, output ready);
endinterface

FILE: src/swvm_front.sv
// ----------------------------------------------------------------------------
// swvm_front
// Accepts commands, keeps the elapsed-seconds count and the scan position,
// and queues one display job per scan tick.
// ----------------------------------------------------------------------------
module swvm_front #(
  parameter int WRAP_SECONDS = swvm_pkg::WRAP_SECONDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  swvm_in_if.sink             item,
  output logic                job_valid,
  input  logic                job_ready,
  output swvm_pkg::swvm_job_t job
);
  import swvm_pkg::*;

  logic [SEC_W-1:0] elapsed;
  logic [POS_W-1:0] scan_pos;
  logic [SEC_W:0]   elapsed_inc;
  logic             accept;

  assign item.ready  = job_ready;
  assign accept      = item.valid && item.ready;
  assign elapsed_inc = {1'b0, elapsed} + (SEC_W+1)'(1);

  assign job_valid      = accept && (item.command == CMD_SCAN);
  assign job.show_volts = item.show_volts;
  assign job.adc_sample = item.adc_sample;
  assign job.elapsed    = elapsed;
  assign job.pos        = scan_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      scan_pos <= '0;
    end else if (accept) begin
      case (item.command)
        CMD_SCAN: begin
          scan_pos <= scan_pos + POS_W'(1);
        end
        CMD_SECOND: begin
          if (elapsed_inc >= (SEC_W+1)'(WRAP_SECONDS)) begin
            elapsed <= '0;
          end else begin
            elapsed <= elapsed_inc[SEC_W-1:0];
          end
        end
        CMD_CLEAR: begin
          elapsed <= '0;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_elapsed_below_wrap: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, elapsed} < (SEC_W+1)'(WRAP_SECONDS)))
    else $error("elapsed count reached wrap value");
`endif

endmodule

FILE: src/swvm_queue.sv
// ----------------------------------------------------------------------------
// swvm_queue
// Short job queue between the command front and the digit back end.
// ----------------------------------------------------------------------------
module swvm_queue #(
  parameter int DEPTH = swvm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  swvm_pkg::swvm_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output swvm_pkg::swvm_job_t pop_data
);
  import swvm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  swvm_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)))
    else $error("queue count above depth");
`endif

endmodule

FILE: src/swvm_back.sv
// ----------------------------------------------------------------------------
// swvm_back
// Six-stage digit pipeline: scale the sample or split the time, pick the
// digit by reciprocal multiplication, encode segments, hold the frame.
// ----------------------------------------------------------------------------
module swvm_back #(
  parameter int ADC_BITS = swvm_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  swvm_pkg::swvm_job_t job,
  swvm_cfg_if.sink            cfg,
  swvm_out_if.source          result
);
  import swvm_pkg::*;

  logic [FS_W-1:0]   full_scale;

  logic              en1, en2, en3, en4, en5, en6;

  logic              s1_v, s1_volts;
  logic [POS_W-1:0]  s1_pos;
  logic [SEC_W-1:0]  s1_es;
  logic [PROD_W-1:0] s1_prod;

  logic              s2_v, s2_volts;
  logic [POS_W-1:0]  s2_pos;
  logic [SEC_W-1:0]  s2_es;
  logic [VAL_W-1:0]  s2_cv;
  logic [MIN_W-1:0]  s2_mins;

  logic              s3_v;
  logic [POS_W-1:0]  s3_pos, s3_k;
  logic [VAL_W-1:0]  s3_val;

  logic              s4_v;
  logic [POS_W-1:0]  s4_pos;
  logic [VAL_W-1:0]  s4_q;

  logic              s5_v;
  logic [POS_W-1:0]  s5_pos;
  logic [VAL_W-1:0]  s5_q, s5_q10;

  logic              out_v;
  logic [SEG_W-1:0]  out_seg;
  logic [SEL_W-1:0]  out_sel;
  logic [POS_W-1:0]  out_pos;

  logic [PROD_W-1:0] scaled;
  logic [VAL_W-1:0]  cv_next;
  logic [MUL_W-1:0]  mins_prod;
  logic [SEC_W-1:0]  secs_full;
  logic [SECS_W-1:0] secs;
  logic [VAL_W-1:0]  val_next;
  logic [POS_W-1:0]  k_next;
  logic [MUL_W-1:0]  q_prod;
  logic [MUL_W-1:0]  q10_prod;
  logic [VAL_W-1:0]  dig_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      full_scale <= cfg.full_scale_centivolts;
    end
  end

  // advance a stage when it is empty or its contents move on
  assign en6       = !out_v || result.ready;
  assign en5       = !s5_v || en6;
  assign en4       = !s4_v || en5;
  assign en3       = !s3_v || en4;
  assign en2       = !s2_v || en3;
  assign en1       = !s1_v || en2;
  assign job_ready = en1;

  assign scaled    = s1_prod >> ADC_BITS;
  assign cv_next   = (scaled > PROD_W'(VAL_MAX)) ? VAL_MAX : scaled[VAL_W-1:0];
  assign mins_prod = MUL_W'(s1_es) * RECIP_60;

  assign secs_full = s2_es - (SEC_W'(s2_mins) * SECS_PER_MIN);
  assign secs      = secs_full[SECS_W-1:0];

  always_comb begin
    if (s2_volts) begin
      val_next = s2_cv;
      k_next   = s2_pos;
    end else if (!s2_pos[1]) begin
      val_next = VAL_W'(secs);
      k_next   = {1'b0, s2_pos[0]};
    end else begin
      val_next = VAL_W'(s2_mins);
      k_next   = {1'b0, s2_pos[0]};
    end
  end

  assign q_prod   = (MUL_W'(s3_val) * MUL_W'(pow10_recip(s3_k))) >> pow10_shift(s3_k);
  assign q10_prod = (MUL_W'(s4_q) * RECIP_10) >> RECIP_10_SH;
  assign dig_full = s5_q - (s5_q10 * TEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en1) s1_v  <= job_valid;
      if (en2) s2_v  <= s1_v;
      if (en3) s3_v  <= s2_v;
      if (en4) s4_v  <= s3_v;
      if (en5) s5_v  <= s4_v;
      if (en6) out_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_volts <= job.show_volts;
      s1_pos   <= job.pos;
      s1_es    <= job.elapsed;
      s1_prod  <= PROD_W'(job.adc_sample) * PROD_W'(full_scale);
    end
    if (en2) begin
      s2_volts <= s1_volts;
      s2_pos   <= s1_pos;
      s2_es    <= s1_es;
      s2_cv    <= cv_next;
      s2_mins  <= mins_prod[RECIP_60_SH +: MIN_W];
    end
    if (en3) begin
      s3_pos <= s2_pos;
      s3_val <= val_next;
      s3_k   <= k_next;
    end
    if (en4) begin
      s4_pos <= s3_pos;
      s4_q   <= q_prod[VAL_W-1:0];
    end
    if (en5) begin
      s5_pos <= s4_pos;
      s5_q   <= s4_q;
      s5_q10 <= q10_prod[VAL_W-1:0];
    end
    if (en6) begin
      out_pos <= s5_pos;
      out_sel <= SEL_POS0 >> s5_pos;
      out_seg <= seg_of(dig_full[DIG_W-1:0]);
    end
  end

  assign result.valid          = out_v;
  assign result.segment_code   = out_seg;
  assign result.digit_select   = out_sel;
  assign result.digit_position = out_pos;

`ifndef SYNTHESIS
  a_cv_saturated: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (s2_cv <= VAL_MAX))
    else $error("centivolt value above four digits");
  a_digit_in_range: assert property (@(posedge clk) disable iff (rst)
    s5_v |-> ((s5_q10 * TEN) <= s5_q && dig_full < TEN))
    else $error("digit extraction out of range");
  a_select_matches_pos: assert property (@(posedge clk) disable iff (rst)
    out_v |-> ($onehot(out_sel) && out_sel == (SEL_POS0 >> out_pos)))
    else $error("digit select does not match position");
`endif

endmodule

FILE: src/stopwatch_voltmeter_seven_segment_scan.sv
// A scan tick's job passes the queue, stages s1 to s5 and the output register.
// Throughput: one command per cycle while the queue has room; queue and the
// six-stage pipeline take one job per cycle until output stalls fill the queue.
// Second and clear ticks update the count in the cycle they are accepted.
// Reset (synchronous): count, scan position, queue and pipeline clear;
// full scale returns to 330 centivolts.
// ----------------------------------------------------------------------------
// stopwatch_voltmeter_seven_segment_scan
// Four-digit multiplexed seven-segment driver showing min:sec or volts.
// ----------------------------------------------------------------------------
module stopwatch_voltmeter_seven_segment_scan #(
  parameter int ADC_BITS     = swvm_pkg::ADC_BITS_DEF,
  parameter int WRAP_SECONDS = swvm_pkg::WRAP_SECONDS_DEF,
  parameter int QUEUE_DEPTH  = swvm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  swvm_in_if.sink     item,
  swvm_cfg_if.sink    cfg,
  swvm_out_if.source  result
);
  import swvm_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  swvm_job_t push_job, pop_job;

  swvm_front #(
    .WRAP_SECONDS(WRAP_SECONDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  swvm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  swvm_back #(
    .ADC_BITS(ADC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
